FILE: design/wpd_pkg.sv
// ----------------------------------------------------------------------------
// wpd_pkg
// Shared types, codes and helpers for the WAV PCM stream decoder.
// ----------------------------------------------------------------------------
package wpd_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_CHUNKHDR,
        PH_FMT,
        PH_DATA,
        PH_SKIP,
        PH_PAD,
        PH_STOP,
        PH_DONE
    } phase_t;

    // Status codes
    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_CHANNELS_REQ = 4'd1;
    localparam logic [3:0] ST_SHORT       = 4'd2;
    localparam logic [3:0] ST_NOT_RIFF    = 4'd3;
    localparam logic [3:0] ST_BAD_SIZE    = 4'd4;
    localparam logic [3:0] ST_FMT_SHORT   = 4'd5;
    localparam logic [3:0] ST_FORMAT      = 4'd6;
    localparam logic [3:0] ST_RATE        = 4'd7;
    localparam logic [3:0] ST_CHANNELS    = 4'd8;
    localparam logic [3:0] ST_DEPTH       = 4'd9;
    localparam logic [3:0] ST_MISSING     = 4'd10;
    localparam logic [3:0] ST_DATA_EARLY  = 4'd11;

    // Chunk tags, little-endian byte order
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // Format codes
    localparam logic [15:0] FMT_PCM   = 16'd1;
    localparam logic [15:0] FMT_FLOAT = 16'd3;

    // Register indexes
    localparam logic [1:0] REG_FILE_LENGTH = 2'd0;
    localparam logic [1:0] REG_SAMPLE_RATE = 2'd1;
    localparam logic [1:0] REG_CHANNELS    = 2'd2;

    // Register reset values
    localparam logic [31:0] RATE_RESET     = 32'd16000;
    localparam logic [15:0] CHANNELS_RESET = 16'd1;

    // Output queue depth and result pipeline length
    localparam int OUT_DEPTH   = 8;
    localparam int PIPE_STAGES = 4;

    // Frame request from the parser to the sample converter
    typedef struct packed {
        logic        sample_vld;
        logic        status_vld;
        logic [3:0]  code;
        logic        is_float;
        logic        stereo;
        logic [63:0] frame;
    } frame_evt_t;

    // Converted result
    typedef struct packed {
        logic        sample_vld;
        logic        status_vld;
        logic [3:0]  code;
        logic [31:0] bits;
    } result_t;

    // Leading zero count of a 27-bit word (27 when all zero)
    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] n;
        n = 5'd27;
        for (int i = 0; i < 27; i++) begin
            if (v[i]) begin
                n = 5'(26 - i);
            end
        end
        return n;
    endfunction

endpackage

FILE: design/wpd_parser.sv
// ----------------------------------------------------------------------------
// wpd_parser
// Byte-at-a-time RIFF/WAVE chunk walker; emits frame and status requests.
// ----------------------------------------------------------------------------
module wpd_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          file_byte,
    input  logic                end_of_file,
    input  logic [31:0]         file_length,
    input  logic [31:0]         expected_sample_rate,
    input  logic [15:0]         requested_channels,
    output wpd_pkg::frame_evt_t evt
);

    wpd_pkg::phase_t     ph_reg, ph_next;
    logic [31:0]         pos_reg, pos_next;
    logic [31:0]         tag_reg, tag_next;
    logic [31:0]         len_reg, len_next;
    logic [31:0]         left_reg, left_next;
    logic [15:0]         fc_reg, fc_next;
    logic [15:0]         ch_reg, ch_next;
    logic [31:0]         rate_reg, rate_next;
    logic [15:0]         dep_reg, dep_next;
    logic                fmt_seen_reg, fmt_seen_next;
    logic                data_seen_reg, data_seen_next;
    logic [3:0]          err_reg, err_next;
    logic [63:0]         fb_reg, fb_next;
    logic [3:0]          fbc_reg, fbc_next;
    wpd_pkg::frame_evt_t evt_reg, evt_next;

    // Next state and requests
    always_comb
    begin
        logic [31:0] tag_w;
        logic [31:0] len_w;
        logic [31:0] remaining;
        logic [31:0] size;
        logic [31:0] off;
        logic [31:0] left_dec;
        logic [15:0] fc_w;
        logic [15:0] ch_w;
        logic [31:0] rate_w;
        logic [15:0] dep_w;
        logic        fmt_fail;
        logic [63:0] fb_w;
        logic [2:0]  fbc_inc;
        logic [3:0]  flen;

        ph_next        = ph_reg;
        pos_next       = pos_reg;
        tag_next       = tag_reg;
        len_next       = len_reg;
        left_next      = left_reg;
        fc_next        = fc_reg;
        ch_next        = ch_reg;
        rate_next      = rate_reg;
        dep_next       = dep_reg;
        fmt_seen_next  = fmt_seen_reg;
        data_seen_next = data_seen_reg;
        err_next       = err_reg;
        fb_next        = fb_reg;
        fbc_next       = fbc_reg;

        evt_next            = '0;
        evt_next.is_float   = (fc_reg == wpd_pkg::FMT_FLOAT);
        evt_next.stereo     = (ch_reg == 16'd2);

        tag_w     = '0;
        len_w     = '0;
        remaining = '0;
        size      = '0;
        off       = len_reg - left_reg;
        left_dec  = left_reg - 32'd1;
        fc_w      = fc_reg;
        ch_w      = ch_reg;
        rate_w    = rate_reg;
        dep_w     = dep_reg;
        fmt_fail  = 1'b0;
        fb_w      = fb_reg;
        fbc_inc   = fbc_reg[2:0] + 3'd1;
        flen      = (ch_reg == 16'd2) ? ((fc_reg == wpd_pkg::FMT_FLOAT) ? 4'd8 : 4'd4)
                                      : ((fc_reg == wpd_pkg::FMT_FLOAT) ? 4'd4 : 4'd2);

        if (accept && ph_reg != wpd_pkg::PH_DONE)
        begin
            // advance the byte position, holding at the top
            if (pos_reg != '1)
            begin
                pos_next = pos_reg + 32'd1;
            end

            if (requested_channels == 16'd1 && file_length >= 32'd12 &&
                pos_reg < file_length)
            begin
                case (ph_reg)
                    wpd_pkg::PH_HEADER:
                    begin
                        if (pos_reg < 32'd4 &&
                            file_byte != wpd_pkg::TAG_RIFF[8*pos_reg[1:0] +: 8])
                        begin
                            err_next = wpd_pkg::ST_NOT_RIFF;
                            ph_next  = wpd_pkg::PH_STOP;
                        end
                        else if (pos_reg >= 32'd8 && pos_reg < 32'd12 &&
                                 file_byte != wpd_pkg::TAG_WAVE[8*pos_reg[1:0] +: 8])
                        begin
                            err_next = wpd_pkg::ST_NOT_RIFF;
                            ph_next  = wpd_pkg::PH_STOP;
                        end
                        else if (pos_reg == 32'd11)
                        begin
                            ph_next  = wpd_pkg::PH_CHUNKHDR;
                            fbc_next = '0;
                        end
                    end

                    wpd_pkg::PH_CHUNKHDR:
                    begin
                        if (fbc_reg == 4'd0 &&
                            ({1'b0, pos_reg} + 33'd8) > {1'b0, file_length})
                        begin
                            // trailing bytes too few for a chunk header
                            ph_next = wpd_pkg::PH_STOP;
                        end
                        else
                        begin
                            tag_w = (fbc_reg == 4'd0) ? '0 : tag_reg;
                            len_w = (fbc_reg == 4'd0) ? '0 : len_reg;
                            if (fbc_reg < 4'd4)
                            begin
                                tag_w[8*fbc_reg[1:0] +: 8] = file_byte;
                            end
                            else
                            begin
                                len_w[8*fbc_reg[1:0] +: 8] = file_byte;
                            end
                            tag_next = tag_w;
                            len_next = len_w;
                            fbc_next = fbc_reg + 4'd1;

                            // header complete: open the chunk
                            if (fbc_reg == 4'd7)
                            begin
                                remaining = file_length - pos_reg - 32'd1;
                                if (len_w > remaining && tag_w != wpd_pkg::TAG_DATA)
                                begin
                                    err_next = wpd_pkg::ST_BAD_SIZE;
                                    ph_next  = wpd_pkg::PH_STOP;
                                end
                                else
                                begin
                                    size      = (len_w > remaining) ? remaining : len_w;
                                    len_next  = size;
                                    left_next = size;
                                    fbc_next  = '0;
                                    fb_next   = '0;
                                    if (tag_w == wpd_pkg::TAG_FMT && !data_seen_reg)
                                    begin
                                        if (size < 32'd16)
                                        begin
                                            err_next = wpd_pkg::ST_FMT_SHORT;
                                            ph_next  = wpd_pkg::PH_STOP;
                                        end
                                        else
                                        begin
                                            ph_next = wpd_pkg::PH_FMT;
                                        end
                                    end
                                    else if (tag_w == wpd_pkg::TAG_DATA && !data_seen_reg)
                                    begin
                                        if (!fmt_seen_reg)
                                        begin
                                            err_next = wpd_pkg::ST_DATA_EARLY;
                                            ph_next  = wpd_pkg::PH_STOP;
                                        end
                                        else
                                        begin
                                            data_seen_next = 1'b1;
                                            ph_next = (size == '0) ? wpd_pkg::PH_CHUNKHDR
                                                                   : wpd_pkg::PH_DATA;
                                        end
                                    end
                                    else
                                    begin
                                        ph_next = (size == '0) ? wpd_pkg::PH_CHUNKHDR
                                                               : wpd_pkg::PH_SKIP;
                                    end
                                end
                            end
                        end
                    end

                    wpd_pkg::PH_FMT:
                    begin
                        // capture the fmt fields
                        if (off == 32'd0)
                        begin
                            fc_w   = {8'd0, file_byte};
                            ch_w   = '0;
                            rate_w = '0;
                            dep_w  = '0;
                        end
                        else if (off == 32'd1)
                        begin
                            fc_w[15:8] = file_byte;
                        end
                        else if (off == 32'd2)
                        begin
                            ch_w[7:0] = file_byte;
                        end
                        else if (off == 32'd3)
                        begin
                            ch_w[15:8] = file_byte;
                        end
                        else if (off < 32'd8)
                        begin
                            rate_w[8*off[1:0] +: 8] = file_byte;
                        end
                        else if (off == 32'd14)
                        begin
                            dep_w[7:0] = file_byte;
                        end
                        else if (off == 32'd15)
                        begin
                            dep_w[15:8] = file_byte;
                        end
                        fc_next   = fc_w;
                        ch_next   = ch_w;
                        rate_next = rate_w;
                        dep_next  = dep_w;
                        left_next = left_dec;

                        // validate once the bit depth is in
                        if (off == 32'd15)
                        begin
                            fmt_fail = 1'b1;
                            if (fc_w != wpd_pkg::FMT_PCM && fc_w != wpd_pkg::FMT_FLOAT)
                            begin
                                err_next = wpd_pkg::ST_FORMAT;
                            end
                            else if (rate_w != expected_sample_rate)
                            begin
                                err_next = wpd_pkg::ST_RATE;
                            end
                            else if (ch_w != 16'd1 && ch_w != 16'd2)
                            begin
                                err_next = wpd_pkg::ST_CHANNELS;
                            end
                            else if (fc_w == wpd_pkg::FMT_PCM && dep_w != 16'd16)
                            begin
                                err_next = wpd_pkg::ST_DEPTH;
                            end
                            else if (fc_w == wpd_pkg::FMT_FLOAT && dep_w != 16'd32)
                            begin
                                err_next = wpd_pkg::ST_DEPTH;
                            end
                            else
                            begin
                                fmt_fail      = 1'b0;
                                fmt_seen_next = 1'b1;
                            end
                            if (fmt_fail)
                            begin
                                ph_next = wpd_pkg::PH_STOP;
                            end
                        end

                        if (!fmt_fail && left_dec == '0)
                        begin
                            ph_next  = len_reg[0] ? wpd_pkg::PH_PAD : wpd_pkg::PH_CHUNKHDR;
                            fbc_next = '0;
                        end
                    end

                    wpd_pkg::PH_DATA:
                    begin
                        // gather frame bytes, send a frame when full
                        fb_w[8*fbc_reg[2:0] +: 8] = file_byte;
                        if (fbc_inc == flen[2:0])
                        begin
                            evt_next.sample_vld = 1'b1;
                            evt_next.frame      = fb_w;
                            fb_next             = '0;
                            fbc_next            = '0;
                        end
                        else
                        begin
                            fb_next  = fb_w;
                            fbc_next = {1'b0, fbc_inc};
                        end
                        left_next = left_dec;
                        if (left_dec == '0)
                        begin
                            ph_next  = len_reg[0] ? wpd_pkg::PH_PAD : wpd_pkg::PH_CHUNKHDR;
                            fbc_next = '0;
                        end
                    end

                    wpd_pkg::PH_SKIP:
                    begin
                        left_next = left_dec;
                        if (left_dec == '0)
                        begin
                            ph_next  = len_reg[0] ? wpd_pkg::PH_PAD : wpd_pkg::PH_CHUNKHDR;
                            fbc_next = '0;
                        end
                    end

                    wpd_pkg::PH_PAD:
                    begin
                        ph_next  = wpd_pkg::PH_CHUNKHDR;
                        fbc_next = '0;
                    end

                    default:
                    begin
                    end
                endcase
            end

            // close the stream with a status
            if (end_of_file)
            begin
                evt_next.status_vld = 1'b1;
                if (requested_channels != 16'd1)
                begin
                    evt_next.code = wpd_pkg::ST_CHANNELS_REQ;
                end
                else if (file_length < 32'd12)
                begin
                    evt_next.code = wpd_pkg::ST_SHORT;
                end
                else if (err_next != wpd_pkg::ST_OK)
                begin
                    evt_next.code = err_next;
                end
                else if (ph_next == wpd_pkg::PH_HEADER)
                begin
                    evt_next.code = wpd_pkg::ST_SHORT;
                end
                else if (!fmt_seen_next || !data_seen_next)
                begin
                    evt_next.code = wpd_pkg::ST_MISSING;
                end
                else
                begin
                    evt_next.code = wpd_pkg::ST_OK;
                end
                ph_next = wpd_pkg::PH_DONE;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg         <= wpd_pkg::PH_HEADER;
            pos_reg        <= '0;
            tag_reg        <= '0;
            len_reg        <= '0;
            left_reg       <= '0;
            fc_reg         <= '0;
            ch_reg         <= '0;
            rate_reg       <= '0;
            dep_reg        <= '0;
            fmt_seen_reg   <= 1'b0;
            data_seen_reg  <= 1'b0;
            err_reg        <= wpd_pkg::ST_OK;
            fb_reg         <= '0;
            fbc_reg        <= '0;
            evt_reg        <= '0;
        end
        else
        begin
            ph_reg         <= ph_next;
            pos_reg        <= pos_next;
            tag_reg        <= tag_next;
            len_reg        <= len_next;
            left_reg       <= left_next;
            fc_reg         <= fc_next;
            ch_reg         <= ch_next;
            rate_reg       <= rate_next;
            dep_reg        <= dep_next;
            fmt_seen_reg   <= fmt_seen_next;
            data_seen_reg  <= data_seen_next;
            err_reg        <= err_next;
            fb_reg         <= fb_next;
            fbc_reg        <= fbc_next;
            evt_reg        <= evt_next;
        end
    end

    assign evt = evt_reg;

endmodule

FILE: design/wpd_sample_conv.sv
// ----------------------------------------------------------------------------
// wpd_sample_conv
// Three-stage frame to single-precision converter: align, add, round.
// ----------------------------------------------------------------------------
module wpd_sample_conv (
    input  logic                clk,
    input  logic                rst_n,
    input  wpd_pkg::frame_evt_t evt,
    output wpd_pkg::result_t    res
);

    // Align stage registers
    logic        a_sample_reg, a_status_reg;
    logic [3:0]  a_code_reg;
    logic        a_bypass_reg;
    logic [31:0] a_val_reg;
    logic        a_halve_reg;
    logic        a_sign_reg;
    logic        a_sub_reg;
    logic [9:0]  a_exp_reg;
    logic [26:0] a_big_reg;
    logic [26:0] a_small_reg;

    // Add stage registers
    logic        b_sample_reg, b_status_reg;
    logic [3:0]  b_code_reg;
    logic        b_bypass_reg;
    logic [31:0] b_val_reg;
    logic        b_halve_reg;
    logic        b_sign_reg;
    logic        b_zsign_reg;
    logic [9:0]  b_exp_reg;
    logic [27:0] b_sum_reg;
    logic [4:0]  b_lz_reg;

    // Round stage registers
    logic        c_sample_reg;
    logic        c_status_reg;
    logic [3:0]  c_code_reg;
    logic [31:0] c_bits_reg;

    // Align: unpack, handle specials, shift the smaller operand
    logic        a_bypass_next;
    logic [31:0] a_val_next;
    logic        a_halve_next;
    logic        a_sign_next;
    logic        a_sub_next;
    logic [9:0]  a_exp_next;
    logic [26:0] a_big_next;
    logic [26:0] a_small_next;

    always_comb
    begin
        logic [31:0] fa;
        logic [31:0] fb;
        logic [31:0] x;
        logic [31:0] y;
        logic [7:0]  ex;
        logic [7:0]  ey;
        logic [23:0] mx;
        logic [23:0] my;
        logic [7:0]  d;
        logic [26:0] sm;
        logic [26:0] mask;
        logic [16:0] s17;
        logic [16:0] mag;

        fa   = evt.frame[31:0];
        fb   = evt.frame[63:32];
        x    = '0;
        y    = '0;
        ex   = '0;
        ey   = '0;
        mx   = '0;
        my   = '0;
        d    = '0;
        sm   = '0;
        mask = '0;
        s17  = '0;
        mag  = '0;

        a_bypass_next = 1'b0;
        a_val_next    = '0;
        a_halve_next  = 1'b0;
        a_sign_next   = 1'b0;
        a_sub_next    = 1'b0;
        a_exp_next    = '0;
        a_big_next    = '0;
        a_small_next  = '0;

        if (!evt.is_float)
        begin
            // PCM: exact integer sum scaled by the exponent
            if (evt.stereo)
            begin
                s17 = {fa[15], fa[15:0]} + {fa[31], fa[31:16]};
                a_exp_next = 10'd137;
            end
            else
            begin
                s17 = {fa[15], fa[15:0]};
                a_exp_next = 10'd138;
            end
            mag         = s17[16] ? (17'd0 - s17) : s17;
            a_sign_next = s17[16];
            a_big_next  = {10'd0, mag};
        end
        else if (!evt.stereo)
        begin
            a_bypass_next = 1'b1;
            a_val_next    = fa;
        end
        else if (fa[30:23] == 8'hFF || fb[30:23] == 8'hFF)
        begin
            // NaN and infinity operands
            a_bypass_next = 1'b1;
            if (fa[30:23] == 8'hFF && fa[22:0] != '0)
            begin
                a_val_next = fa | 32'h0040_0000;
            end
            else if (fb[30:23] == 8'hFF && fb[22:0] != '0)
            begin
                a_val_next = fb | 32'h0040_0000;
            end
            else if (fa[30:23] == 8'hFF && fb[30:23] == 8'hFF && fa[31] != fb[31])
            begin
                a_val_next = 32'hFFC0_0000;
            end
            else if (fa[30:23] == 8'hFF)
            begin
                a_val_next = fa;
            end
            else
            begin
                a_val_next = fb;
            end
        end
        else
        begin
            // order by magnitude so the larger one leads
            if (fb[30:0] > fa[30:0])
            begin
                x = fb;
                y = fa;
            end
            else
            begin
                x = fa;
                y = fb;
            end
            ex   = (x[30:23] == '0) ? 8'd1 : x[30:23];
            ey   = (y[30:23] == '0) ? 8'd1 : y[30:23];
            mx   = {x[30:23] != '0, x[22:0]};
            my   = {y[30:23] != '0, y[22:0]};
            d    = ex - ey;
            sm   = {my, 3'b000};
            if (d >= 8'd27)
            begin
                a_small_next = {26'd0, |my};
            end
            else
            begin
                mask = ~({27{1'b1}} << d[4:0]);
                a_small_next = (sm >> d[4:0]) | {26'd0, |(sm & mask)};
            end
            a_big_next   = {mx, 3'b000};
            a_exp_next   = {2'b00, ex};
            a_sign_next  = x[31];
            a_sub_next   = x[31] ^ y[31];
            a_halve_next = 1'b1;
        end
    end

    // Add: magnitude sum and leading zero count
    logic [27:0] b_sum_next;

    always_comb
    begin
        if (a_sub_reg)
        begin
            b_sum_next = {1'b0, a_big_reg} - {1'b0, a_small_reg};
        end
        else
        begin
            b_sum_next = {1'b0, a_big_reg} + {1'b0, a_small_reg};
        end
    end

    // Round: normalize, round to nearest even, then halve if asked
    logic [31:0] c_bits_next;

    always_comb
    begin
        logic [26:0] m;
        logic [9:0]  e1;
        logic [9:0]  e2;
        logic [9:0]  lim;
        logic [9:0]  sh;
        logic        up;
        logic [24:0] mr;
        logic [23:0] mt;
        logic [31:0] r;
        logic [23:0] sig;
        logic [23:0] q;

        m   = '0;
        e1  = '0;
        e2  = '0;
        lim = b_exp_reg - 10'd1;
        sh  = '0;
        mr  = '0;
        mt  = '0;
        r   = '0;
        sig = '0;
        q   = '0;

        if (b_sum_reg[27])
        begin
            m  = {b_sum_reg[27:2], b_sum_reg[1] | b_sum_reg[0]};
            e1 = b_exp_reg + 10'd1;
        end
        else
        begin
            sh = ({5'd0, b_lz_reg} < lim) ? {5'd0, b_lz_reg} : lim;
            m  = b_sum_reg[26:0] << sh;
            e1 = b_exp_reg - sh;
        end

        up = m[2] & (m[1] | m[0] | m[3]);
        mr = {1'b0, m[26:3]} + {24'd0, up};
        if (mr[24])
        begin
            e2 = e1 + 10'd1;
            mt = mr[24:1];
        end
        else
        begin
            e2 = e1;
            mt = mr[23:0];
        end

        if (e2 >= 10'd255)
        begin
            r = {b_sign_reg, 8'hFF, 23'd0};
        end
        else
        begin
            r = {b_sign_reg, mt[23] ? e2[7:0] : 8'd0, mt[22:0]};
        end

        if (b_sum_reg == '0)
        begin
            r = {b_zsign_reg, 31'd0};
        end

        // halve: step the exponent, or shift a small value with rounding
        if (b_halve_reg && r[30:23] != 8'hFF)
        begin
            if (r[30:23] >= 8'd2)
            begin
                r[30:23] = r[30:23] - 8'd1;
            end
            else
            begin
                sig = {r[30:23] != '0, r[22:0]};
                q   = (sig >> 1) + {23'd0, sig[0] & sig[1]};
                r   = {r[31], 7'd0, q};
            end
        end

        c_bits_next = b_bypass_reg ? b_val_reg : r;
    end

    // Pipeline registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_sample_reg <= 1'b0;
            a_status_reg <= 1'b0;
            b_sample_reg <= 1'b0;
            b_status_reg <= 1'b0;
            c_sample_reg <= 1'b0;
            c_status_reg <= 1'b0;
        end
        else
        begin
            a_sample_reg <= evt.sample_vld;
            a_status_reg <= evt.status_vld;
            b_sample_reg <= a_sample_reg;
            b_status_reg <= a_status_reg;
            c_sample_reg <= b_sample_reg;
            c_status_reg <= b_status_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_code_reg   <= evt.code;
        a_bypass_reg <= a_bypass_next;
        a_val_reg    <= a_val_next;
        a_halve_reg  <= a_halve_next;
        a_sign_reg   <= a_sign_next;
        a_sub_reg    <= a_sub_next;
        a_exp_reg    <= a_exp_next;
        a_big_reg    <= a_big_next;
        a_small_reg  <= a_small_next;

        b_code_reg   <= a_code_reg;
        b_bypass_reg <= a_bypass_reg;
        b_val_reg    <= a_val_reg;
        b_halve_reg  <= a_halve_reg;
        b_sign_reg   <= a_sign_reg;
        b_zsign_reg  <= a_sub_reg ? 1'b0 : a_sign_reg;
        b_exp_reg    <= a_exp_reg;
        b_sum_reg    <= b_sum_next;
        b_lz_reg     <= wpd_pkg::lzc27(b_sum_next[26:0]);

        c_code_reg   <= b_code_reg;
        c_bits_reg   <= c_bits_next;
    end

    assign res = {c_sample_reg, c_status_reg, c_code_reg, c_bits_reg};

endmodule

FILE: design/wav_pcm_stream_decoder.sv
// ----------------------------------------------------------------------------
// wav_pcm_stream_decoder
// RIFF/WAVE byte stream to mono single-precision samples with a final status.
// ----------------------------------------------------------------------------
// The block takes one file byte per clock while in_ready is high. Each byte is
// parsed in the cycle it is accepted; a completed frame is then registered as a
// request and passes a three-stage float pipeline (align, add, round) into the
// output queue. The final status follows the last sample. in_ready stays high
// as long as the output queue can absorb everything in the pipeline, so with a
// ready consumer the rate is one byte per cycle; the queue depth sets how long
// a stalled consumer can be absorbed. Set file_length, expected_sample_rate and
// requested_channels over the APB port before the first byte.
module wav_pcm_stream_decoder #(
    parameter int OutDepth = wpd_pkg::OUT_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // byte input
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  file_byte,
    input  logic        end_of_file,
    // result output
    output logic        out_valid,
    input  logic        out_ready,
    output logic        is_status,
    output logic [31:0] sample_bits,
    output logic [3:0]  status_code
);

    localparam int PtrW = (OutDepth > 1) ? $clog2(OutDepth) : 1;
    localparam int CntW = $clog2(OutDepth + 1);

    logic [31:0] file_length_reg;
    logic [31:0] rate_reg;
    logic [15:0] channels_reg;

    wpd_pkg::frame_evt_t evt;
    wpd_pkg::result_t    res;

    logic [31:0]     q_mem_reg [OutDepth];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] cnt_reg;
    logic            stat_pend_reg;
    logic [3:0]      stat_code_reg;

    logic accept;
    logic pop;
    logic push;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_length_reg <= '0;
            rate_reg        <= wpd_pkg::RATE_RESET;
            channels_reg    <= wpd_pkg::CHANNELS_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                wpd_pkg::REG_FILE_LENGTH: file_length_reg <= pwdata;
                wpd_pkg::REG_SAMPLE_RATE: rate_reg        <= pwdata;
                wpd_pkg::REG_CHANNELS:    channels_reg    <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (paddr[3:2])
            wpd_pkg::REG_FILE_LENGTH: prdata = file_length_reg;
            wpd_pkg::REG_SAMPLE_RATE: prdata = rate_reg;
            wpd_pkg::REG_CHANNELS:    prdata = {16'd0, channels_reg};
            default:                  prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Accept a byte only while the queue can take the whole pipeline
    assign in_ready = (32'(cnt_reg) + 32'(wpd_pkg::PIPE_STAGES)) < 32'(OutDepth);
    assign accept   = in_valid && in_ready;

    wpd_parser u_parser (
        .clk                  (clk),
        .rst_n                (rst_n),
        .accept               (accept),
        .file_byte            (file_byte),
        .end_of_file          (end_of_file),
        .file_length          (file_length_reg),
        .expected_sample_rate (rate_reg),
        .requested_channels   (channels_reg),
        .evt                  (evt)
    );

    wpd_sample_conv u_conv (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt),
        .res   (res)
    );

    // Output queue: samples first, then the held status
    assign push = res.sample_vld;
    assign pop  = out_valid && out_ready && (cnt_reg != '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= res.bits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            cnt_reg       <= '0;
            stat_pend_reg <= 1'b0;
            stat_code_reg <= wpd_pkg::ST_OK;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == OutDepth - 1) ? '0
                                                                : wr_ptr_reg + PtrW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == OutDepth - 1) ? '0
                                                                : rd_ptr_reg + PtrW'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CntW'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - CntW'(1);
            end

            // hold the status until the queue has drained and it is taken
            if (res.status_vld)
            begin
                stat_pend_reg <= 1'b1;
                stat_code_reg <= res.code;
            end
            else if (out_valid && out_ready && cnt_reg == '0)
            begin
                stat_pend_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = (cnt_reg != '0) || stat_pend_reg;
    assign is_status   = (cnt_reg == '0);
    assign sample_bits = (cnt_reg != '0) ? q_mem_reg[rd_ptr_reg] : '0;
    assign status_code = (cnt_reg == '0) ? stat_code_reg : wpd_pkg::ST_OK;

endmodule
